FILE: design/plm_pkg.sv
// Shared constants and types for the piecewise linear map.
// No dependencies; imported by plm_div, piecewise_linear_map and plm_checker.
`default_nettype none

package plm_pkg;

    // Table depth and derived widths
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int N_W        = $clog2(MAX_POINTS + 1);
    localparam int CFG_W      = 5;
    localparam int PIDX_W     = 4;
    localparam int CMPC_W     = (N_W > CFG_W) ? N_W : CFG_W;
    localparam int CMPI_W     = (N_W > PIDX_W) ? N_W : PIDX_W;

    // Breakpoint word as stored: input coordinate over output coordinate
    localparam int COORD_W = 16;
    localparam int ENTRY_W = 2 * COORD_W;

    // Divider widths: product magnitude and widened input span
    localparam int DVD_W = 32;
    localparam int DSR_W = 17;
    localparam int CNT_W = $clog2(DVD_W);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_POINT_COUNT = 1'b0;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    // Divider status as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

FILE: design/plm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module plm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                   wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and read on the same edge; read data is registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: design/plm_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on plm_pkg for widths and the status struct.
`default_nettype none

module plm_div
    import plm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output div_status_t           status
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] rem_reg;

    logic [DSR_W:0]   rem_shift;
    logic [DSR_W:0]   rem_diff;
    logic             fits;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        fits      = (rem_shift >= {1'b0, dsr_reg});
    end

    // Control: busy for one pass of all dividend bits, then pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift quotient bits in where dividend bits leave
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? rem_diff[DSR_W-1:0] : rem_shift[DSR_W-1:0];
        end
    end

    assign quotient    = dvd_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

FILE: design/piecewise_linear_map.sv
// Piecewise linear map: a write word (cmd 0) stores one breakpoint and gives
// no result. A map word (cmd 1) walks the table from slot 0, with a RAM read
// and then a compare for each breakpoint examined, and a clamped result goes
// straight to the output step. An interpolated result then passes through
// the span step, the multiply, the serial divider (a 32-bit quotient and the
// done pulse) and the offset and saturation step. The block stalls its input
// while a map word is in progress; a finished result waits in the output
// register and the next word is taken meanwhile.
// Depends on plm_pkg, plm_ram and plm_div.
`default_nettype none

module piecewise_linear_map
    import plm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      cmd,
    input  wire logic [PIDX_W-1:0]         point_index,
    input  wire logic signed [COORD_W-1:0] point_in,
    input  wire logic signed [COORD_W-1:0] point_out,
    input  wire logic signed [COORD_W-1:0] sample,
    // Output channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [COORD_W-1:0]      mapped,
    // Configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [PADDR_W-1:0]        paddr,
    input  wire logic [PDATA_W-1:0]        pwdata,
    output logic      [PDATA_W-1:0]        prdata,
    output logic                           pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_ADD,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CFG_W-1:0]          point_count_reg;
    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] mapped_reg;

    logic [IDX_W-1:0]          idx_reg;
    logic [N_W-1:0]            n_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] lo_in_reg;
    logic signed [COORD_W-1:0] lo_out_reg;
    logic signed [COORD_W-1:0] hi_in_reg;
    logic signed [COORD_W-1:0] hi_out_reg;
    logic signed [COORD_W-1:0] res_reg;
    logic [COORD_W-1:0]        dx_reg;
    logic signed [COORD_W+1:0] span_out_reg;
    logic [DSR_W-1:0]          span_in_reg;
    logic                      neg_reg;

    logic                      in_accept;
    logic                      ram_we;
    logic [ENTRY_W-1:0]        ram_rdata;
    logic signed [COORD_W-1:0] e_in;
    logic signed [COORD_W-1:0] e_out;
    logic                      last_slot;
    logic [N_W-1:0]            n_eff;
    logic [CMPC_W-1:0]         cfg_wide;

    logic signed [COORD_W:0]   span_in_raw;
    logic signed [COORD_W:0]   span_out_raw;
    logic signed [COORD_W+1:0] span_in_adj;
    logic signed [COORD_W+1:0] span_out_adj;
    logic [COORD_W:0]          dx_raw;
    logic [DSR_W-1:0]          out_mag;
    logic [DSR_W+COORD_W-1:0]  product;

    logic                      div_start;
    logic [DVD_W-1:0]          div_q;
    div_status_t               div_stat;
    logic signed [DVD_W:0]     q_signed;
    logic signed [DVD_W+1:0]   sum;
    logic signed [COORD_W-1:0] sat_val;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign mapped    = mapped_reg;

    // Configuration port: always ready, one register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POINT_COUNT) ? PDATA_W'(point_count_reg) : '0;

    // Breakpoint store; writes to slots past the table are dropped
    assign ram_we = in_accept && (cmd == CMD_WRITE)
                    && (CMPI_W'(point_index) < CMPI_W'(MAX_POINTS));

    plm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(IDX_W'(point_index)),
        .wdata({point_in, point_out}),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    assign e_in      = ram_rdata[ENTRY_W-1:COORD_W];
    assign e_out     = ram_rdata[COORD_W-1:0];
    assign last_slot = ((N_W'(idx_reg) + N_W'(1)) == n_reg);

    // Clamp the breakpoint count to 1..MAX_POINTS
    always_comb
    begin
        cfg_wide = CMPC_W'(point_count_reg);
        if (cfg_wide == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (cfg_wide > CMPC_W'(MAX_POINTS))
        begin
            n_eff = N_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = N_W'(cfg_wide);
        end
    end

    // Spans, widened by one when the input span exceeds the output span
    always_comb
    begin
        span_in_raw  = (COORD_W+1)'(hi_in_reg) - (COORD_W+1)'(lo_in_reg);
        span_out_raw = (COORD_W+1)'(hi_out_reg) - (COORD_W+1)'(lo_out_reg);
        span_in_adj  = (COORD_W+2)'(span_in_raw);
        span_out_adj = (COORD_W+2)'(span_out_raw);
        if (span_in_raw > span_out_raw)
        begin
            span_in_adj  = span_in_adj + (COORD_W+2)'(1);
            span_out_adj = span_out_adj + (COORD_W+2)'(1);
        end
        dx_raw = (COORD_W+1)'(x_reg) - (COORD_W+1)'(lo_in_reg);
    end

    // Magnitude product for the divider
    always_comb
    begin
        out_mag = span_out_reg[COORD_W+1] ? DSR_W'(-span_out_reg) : DSR_W'(span_out_reg);
        product = dx_reg * out_mag;
    end

    assign div_start = (state_reg == S_MUL);

    plm_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(product[DVD_W-1:0]),
        .divisor (span_in_reg),
        .quotient(div_q),
        .status  (div_stat)
    );

    // Restore the sign, add the low output and saturate
    always_comb
    begin
        q_signed = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        sum      = (DVD_W+2)'(q_signed) + (DVD_W+2)'(lo_out_reg);
        if (sum > (DVD_W+2)'(32767))
        begin
            sat_val = 16'sh7FFF;
        end
        else if (sum < -(DVD_W+2)'(32768))
        begin
            sat_val = -16'sh8000;
        end
        else
        begin
            sat_val = sum[COORD_W-1:0];
        end
    end

    // Sequencer: walk the table, then run the interpolation steps
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (cmd == CMD_MAP))
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (x_reg > e_in)
                begin
                    state_next = last_slot ? S_OUT : S_FETCH;
                end
                else if (idx_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, count register and the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            point_count_reg <= CFG_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && pready && (paddr[2] == REG_POINT_COUNT))
            begin
                point_count_reg <= pwdata[CFG_W-1:0];
            end
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the walk and the arithmetic
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg   <= sample;
                n_reg   <= n_eff;
                idx_reg <= '0;
            end
            S_CHECK:
            begin
                if (x_reg > e_in)
                begin
                    res_reg    <= e_out;
                    lo_in_reg  <= e_in;
                    lo_out_reg <= e_out;
                    if (!last_slot)
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    res_reg    <= e_out;
                    hi_in_reg  <= e_in;
                    hi_out_reg <= e_out;
                end
            end
            S_SETUP:
            begin
                span_in_reg  <= DSR_W'(span_in_adj);
                span_out_reg <= span_out_adj;
                dx_reg       <= dx_raw[COORD_W-1:0];
                neg_reg      <= span_out_adj[COORD_W+1];
            end
            S_ADD:
            begin
                res_reg <= sat_val;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    mapped_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/plm_checker.sv
// Port-level checks for the piecewise linear map, bound to the top level.
// Depends on plm_pkg and on the ports of piecewise_linear_map.
`default_nettype none

module plm_checker
    import plm_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                cmd,
    input wire logic [PIDX_W-1:0]   point_index,
    input wire logic [COORD_W-1:0]  point_in,
    input wire logic [COORD_W-1:0]  point_out,
    input wire logic [COORD_W-1:0]  sample,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [COORD_W-1:0]  mapped,
    input wire logic                psel,
    input wire logic                penable,
    input wire logic                pwrite,
    input wire logic [PADDR_W-1:0]  paddr,
    input wire logic [PDATA_W-1:0]  pwdata,
    input wire logic [PDATA_W-1:0]  prdata,
    input wire logic                pready
);

    // A stalled result word stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(mapped))
        else $error("result word changed while stalled");

    // A map word occupies the block for the next cycle
    a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_MAP) |=> in_stall)
        else $error("input taken right after a map word");

    // A write word completes in its own cycle
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_WRITE) |=> !in_stall)
        else $error("write word held the input");

endmodule

bind piecewise_linear_map plm_checker u_plm_checker (.*);

`default_nettype wire
